// ===== rtl/core/lsi_pkg.sv =====
// Package for the line start index block: widths, operation and status codes.
// No dependencies.
package lsi_pkg;
    localparam int MAX_LINES = 4096;
    localparam int POS_BITS  = 24;
    localparam int IDX_BITS  = $clog2(MAX_LINES);
    localparam int CNT_BITS  = IDX_BITS + 1;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_BYTE  = 3'd1;
    localparam logic [2:0] OP_EOT   = 3'd2;
    localparam logic [2:0] OP_FIND  = 3'd3;
    localparam logic [2:0] OP_INFO  = 3'd4;
    localparam logic [2:0] OP_EDIT  = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_BADEDIT = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    typedef struct packed {
        logic [2:0]          operation;
        logic [7:0]          data_byte;
        logic [POS_BITS-1:0] byte_position;
        logic [IDX_BITS-1:0] line_number;
        logic [POS_BITS-1:0] bytes_added;
        logic [POS_BITS-1:0] bytes_removed;
    } req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [IDX_BITS-1:0] found_line;
        logic [POS_BITS-1:0] start_offset;
        logic [POS_BITS-1:0] length_bytes;
        logic [1:0]          lines_added;
        logic [CNT_BITS-1:0] total_lines;
    } rsp_t;
endpackage

// ===== rtl/core/lsi_req_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on lsi_pkg.
interface lsi_req_if;
    logic          valid;
    logic          ready;
    lsi_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lsi_rsp_if;
    logic          valid;
    logic          ready;
    lsi_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/line_start_index_top.sv =====
// Top level of the line start index: byte scanner, line table and query/edit sequencer.
// Depends on lsi_pkg, lsi_req_if/lsi_rsp_if and lsi_ram.
//
//  channel | dir | payload                         | handshake
//  req     | in  | operation, byte, position, ...  | valid/ready
//  rsp     | out | status, line, start, length ... | valid/ready
//
// Clear, text byte and unused codes answer from idle; line info first reads both tables.
// End of text: one line, or two after a pending CR (second append on the one write port).
// Find line: walks all start entries, one start entry read per cycle, then reads the hit.
// Edit: same walk; if not refused, writes the new length, then rewrites each later start.
// Reset clears the FSM, line count, offsets and flags; tables hold garbage until written.
// A request is taken only when the previous response has left the output register.
module line_start_index_top (
    input  logic clk,
    input  logic rst_n,
    lsi_req_if.sink   req,
    lsi_rsp_if.source rsp
);
    localparam int IB = lsi_pkg::IDX_BITS;
    localparam int CB = lsi_pkg::CNT_BITS;
    localparam int PB = lsi_pkg::POS_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EOT2  = 4'd1;
    localparam logic [3:0] S_INFO  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_RDHIT = 4'd4;
    localparam logic [3:0] S_HIT   = 4'd5;
    localparam logic [3:0] S_SHRD  = 4'd6;
    localparam logic [3:0] S_SHWR  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [CB-1:0] count_reg, count_next;
    logic [PB-1:0] scan_off_reg, scan_off_next;
    logic [PB-1:0] open_reg, open_next;
    logic pcr_reg, pcr_next;
    logic done_reg, done_next;
    lsi_pkg::req_t cur_reg, cur_next;
    lsi_pkg::rsp_t rsp_reg, rsp_next;
    logic rv_reg, rv_next;
    logic [CB-1:0] idx_reg, idx_next;   // walk index (read address issued)
    logic [IB-1:0] hit_reg, hit_next;
    logic [PB-1:0] shift_reg, shift_next;

    // memory ports
    logic s_we, l_we;
    logic [IB-1:0] s_wa, l_wa, s_ra, l_ra;
    logic [PB-1:0] s_wd, l_wd, s_rd, l_rd;

    lsi_ram #(.WIDTH(PB), .DEPTH(lsi_pkg::MAX_LINES)) u_start (
        .clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
        .rd_addr(s_ra), .rd_data(s_rd));
    lsi_ram #(.WIDTH(PB), .DEPTH(lsi_pkg::MAX_LINES)) u_len (
        .clk(clk), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
        .rd_addr(l_ra), .rd_data(l_rd));

    assign req.ready   = (state_reg == S_IDLE) && !rv_reg;
    assign rsp.valid   = rv_reg;
    assign rsp.payload = rsp_reg;

    logic take;
    assign take = req.valid && req.ready;

    logic signed [PB+1:0] nls;

    always_comb
    begin
        logic [PB-1:0] end1;
        logic [1:0] add;
        logic [2:0] st;
        logic full;
        end1 = scan_off_reg + PB'(1);
        full = (count_reg == CB'(lsi_pkg::MAX_LINES));
        add = 2'd0;
        st = lsi_pkg::ST_OK;

        state_next    = state_reg;
        count_next    = count_reg;
        scan_off_next = scan_off_reg;
        open_next     = open_reg;
        pcr_next      = pcr_reg;
        done_next     = done_reg;
        cur_next      = cur_reg;
        rsp_next      = rsp_reg;
        rv_next       = rv_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        shift_next    = shift_reg;
        s_we = 1'b0; l_we = 1'b0;
        s_wa = count_reg[IB-1:0]; l_wa = count_reg[IB-1:0];
        s_wd = open_reg; l_wd = '0;
        s_ra = idx_reg[IB-1:0]; l_ra = hit_reg;
        nls = '0;

        if (rv_reg && rsp.ready)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cur_next = req.payload;
                    rsp_next = '0;
                    priority case (req.payload.operation)
                        lsi_pkg::OP_CLEAR:
                        begin
                            count_next = '0; scan_off_next = '0; open_next = '0;
                            pcr_next = 1'b0; done_next = 1'b0;
                            rsp_next.total_lines = '0;
                            rv_next = 1'b1;
                        end
                        lsi_pkg::OP_BYTE:
                        begin
                            if (done_reg)
                            begin
                                st = lsi_pkg::ST_DONE;
                            end
                            else
                            begin
                                // one line end at most per byte: a pending CR closes its
                                // line (through the LF when one follows), else LF closes
                                if (pcr_reg)
                                begin
                                    pcr_next = 1'b0;
                                    if (req.payload.data_byte == lsi_pkg::CH_LF)
                                    begin
                                        if (full) st = lsi_pkg::ST_FULL;
                                        else begin s_we = 1'b1; l_we = 1'b1; add = 2'd1; end
                                        l_wd = end1 - open_reg;
                                        open_next = end1;
                                    end
                                    else
                                    begin
                                        if (full) st = lsi_pkg::ST_FULL;
                                        else begin s_we = 1'b1; l_we = 1'b1; add = 2'd1; end
                                        l_wd = scan_off_reg - open_reg;
                                        open_next = scan_off_reg;
                                        if (req.payload.data_byte == lsi_pkg::CH_CR)
                                            pcr_next = 1'b1;
                                    end
                                end
                                else if (req.payload.data_byte == lsi_pkg::CH_LF)
                                begin
                                    if (full) st = lsi_pkg::ST_FULL;
                                    else begin s_we = 1'b1; l_we = 1'b1; add = 2'd1; end
                                    l_wd = end1 - open_reg;
                                    open_next = end1;
                                end
                                else if (req.payload.data_byte == lsi_pkg::CH_CR)
                                begin
                                    pcr_next = 1'b1;
                                end
                                scan_off_next = end1;
                            end
                            count_next = count_reg + CB'(add);
                            rsp_next.status = st;
                            rsp_next.lines_added = add;
                            rsp_next.total_lines = count_next;
                            rv_next = 1'b1;
                        end
                        lsi_pkg::OP_EOT:
                        begin
                            rsp_next.status = lsi_pkg::ST_DONE;
                            rsp_next.total_lines = count_reg;
                            if (done_reg)
                            begin
                                rv_next = 1'b1;
                            end
                            else
                            begin
                                // first append: pending CR line, or the final line
                                if (full) rsp_next.status = lsi_pkg::ST_FULL;
                                else begin s_we = 1'b1; l_we = 1'b1; add = 2'd1; end
                                l_wd = scan_off_reg - open_reg;
                                open_next = scan_off_reg;
                                count_next = count_reg + CB'(add);
                                rsp_next.lines_added = add;
                                rsp_next.total_lines = count_next;
                                pcr_next = 1'b0;
                                done_next = 1'b1;
                                if (pcr_reg) state_next = S_EOT2;
                                else rv_next = 1'b1;
                            end
                        end
                        lsi_pkg::OP_FIND, lsi_pkg::OP_EDIT:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = lsi_pkg::ST_RANGE;
                                rv_next = 1'b1;
                            end
                            else
                            begin
                                s_ra = '0;
                                idx_next = CB'(1);
                                hit_next = '0;
                                state_next = S_SCAN;
                            end
                            rsp_next.total_lines = count_reg;
                        end
                        lsi_pkg::OP_INFO:
                        begin
                            rsp_next.total_lines = count_reg;
                            if (CB'(req.payload.line_number) < count_reg)
                            begin
                                s_ra = req.payload.line_number[IB-1:0];
                                l_ra = req.payload.line_number[IB-1:0];
                                state_next = S_INFO;
                            end
                            else
                            begin
                                rsp_next.status = lsi_pkg::ST_RANGE;
                                rv_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_next.total_lines = count_reg;
                            rv_next = 1'b1;
                        end
                    endcase
                end
            end
            S_EOT2:
            begin
                // second append: empty final line after the lone CR
                if (full) rsp_next.status = lsi_pkg::ST_FULL;
                else
                begin
                    s_we = 1'b1; l_we = 1'b1;
                    rsp_next.lines_added = rsp_reg.lines_added + 2'd1;
                    count_next = count_reg + CB'(1);
                end
                l_wd = '0;
                rsp_next.total_lines = count_next;
                rv_next = 1'b1;
                state_next = S_IDLE;
            end
            S_INFO:
            begin
                rsp_next.start_offset = s_rd;
                rsp_next.length_bytes = l_rd;
                rv_next = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // idx_reg-1 data on s_rd; issue read of idx_reg
                if (s_rd <= cur_reg.byte_position)
                    hit_next = IB'(idx_reg - CB'(1));
                if (idx_reg == count_reg)
                begin
                    state_next = S_RDHIT;
                end
                else
                begin
                    idx_next = idx_reg + CB'(1);
                end
            end
            S_RDHIT:
            begin
                s_ra = hit_reg;
                l_ra = hit_reg;
                state_next = S_HIT;
            end
            S_HIT:
            begin
                rsp_next.found_line = hit_reg;
                rsp_next.start_offset = s_rd;
                rsp_next.length_bytes = l_rd;
                if (cur_reg.operation == lsi_pkg::OP_EDIT)
                begin
                    nls = $signed({2'b00, l_rd}) + $signed({2'b00, cur_reg.bytes_added})
                        - $signed({2'b00, cur_reg.bytes_removed});
                    if (nls[PB+1] || nls[PB])
                    begin
                        rsp_next.status = lsi_pkg::ST_BADEDIT;
                        rv_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        l_we = 1'b1;
                        l_wa = hit_reg;
                        l_wd = nls[PB-1:0];
                        rsp_next.length_bytes = nls[PB-1:0];
                        shift_next = cur_reg.bytes_added - cur_reg.bytes_removed;
                        idx_next = CB'(hit_reg) + CB'(1);
                        state_next = S_SHRD;
                    end
                end
                else
                begin
                    rv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHRD:
            begin
                if (idx_reg >= count_reg)
                begin
                    rv_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    s_ra = idx_reg[IB-1:0];
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                s_we = 1'b1;
                s_wa = idx_reg[IB-1:0];
                s_wd = s_rd + shift_reg;
                idx_next = idx_reg + CB'(1);
                state_next = S_SHRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_off_reg <= '0;
            open_reg     <= '0;
            pcr_reg      <= 1'b0;
            done_reg     <= 1'b0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_off_reg <= scan_off_next;
            open_reg     <= open_next;
            pcr_reg      <= pcr_next;
            done_reg     <= done_next;
            rv_reg       <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        rsp_reg   <= rsp_next;
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        shift_reg <= shift_next;
    end
endmodule

// ===== rtl/core/lsi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/core/lsi_checker.sv =====
// Port-level checker for line_start_index_top, attached by bind.
// Depends on lsi_pkg and the channel interfaces.
module lsi_checker (
    input logic clk,
    input logic rst_n,
    lsi_req_if.sink   req,
    lsi_rsp_if.source rsp
);
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> !(req.valid && req.ready))
        else $error("request taken while response pending");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
        else $error("response dropped or changed under stall");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.payload.status <= lsi_pkg::ST_DONE)
        else $error("bad status code");
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.payload.total_lines <= 13'(lsi_pkg::MAX_LINES))
        else $error("line count above table size");
endmodule

bind line_start_index_top lsi_checker u_lsi_checker (
    .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

// ===== test/line_start_index_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the RTL file lsi_req_if.sv.
// This file holds the request/response helper types used by the bench; depends on lsi_pkg.
package lsi_tb_pkg;
    typedef enum logic [2:0] {
        OPK_CLEAR  = lsi_pkg::OP_CLEAR,
        OPK_BYTE   = lsi_pkg::OP_BYTE,
        OPK_EOT    = lsi_pkg::OP_EOT,
        OPK_FIND   = lsi_pkg::OP_FIND,
        OPK_INFO   = lsi_pkg::OP_INFO,
        OPK_EDIT   = lsi_pkg::OP_EDIT,
        OPK_SPARE6 = 3'd6,
        OPK_SPARE7 = 3'd7
    } op_kind_e;

    // One row of the directed table; chk_fixed checks a typed-in answer against the prediction.
    typedef struct {
        lsi_pkg::req_t req;
        bit            chk_fixed;
        lsi_pkg::rsp_t fixed;
    } stim_row_t;
endpackage

// ===== test/line_start_index_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for line_start_index_top: directed table then random text,
// queries and edits, checked against an in-bench line table. Depends on lsi_pkg, lsi_tb_pkg.
module line_start_index_top_tb;
    localparam int  WATCHDOG_LIMIT = 200000;
    localparam int  N_RANDOM       = 1500;
    localparam logic [23:0] POS_MAX = 24'hFFFFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lsi_req_if req_ch ();
    lsi_rsp_if rsp_ch ();

    line_start_index_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Line table predictor: mirrors the block's table and scan state.
    // ---------------------------------------------------------------
    logic [23:0] line_start [lsi_pkg::MAX_LINES];
    logic [23:0] line_len   [lsi_pkg::MAX_LINES];
    int unsigned line_cnt;
    logic [23:0] scan_pos;
    logic [23:0] open_start;
    bit          cr_pending;
    bit          text_done;

    lsi_pkg::rsp_t expected_rsps[$];
    bit            fixed_flags[$];
    lsi_pkg::rsp_t fixed_rsps[$];

    int unsigned mismatches;
    int unsigned rsp_count;
    int unsigned req_count;
    int unsigned idle_cycles;
    int unsigned edits_done, edits_refused, full_hits;
    bit          hold_off_req;
    bit          held_off;

    function automatic void table_reset();
        line_cnt   = 0;
        scan_pos   = '0;
        open_start = '0;
        cr_pending = 1'b0;
        text_done  = 1'b0;
    endfunction

    // Close the open line at end offset 'stop'; count stores or flag a drop.
    function automatic void close_open_line(input logic [23:0] stop,
                                            inout logic [1:0] added,
                                            inout logic [2:0] st);
        if (line_cnt < lsi_pkg::MAX_LINES)
        begin
            line_start[line_cnt] = open_start;
            line_len[line_cnt]   = stop - open_start;
            line_cnt++;
            added++;
        end
        else
        begin
            st = lsi_pkg::ST_FULL;
        end
        open_start = stop;
    endfunction

    function automatic lsi_pkg::rsp_t predict_line_rsp(input lsi_pkg::req_t r);
        lsi_pkg::rsp_t o;
        logic [7:0]    ch;
        int unsigned   hit;
        longint        net, nl;
        o  = '0;
        ch = r.data_byte;
        case (lsi_tb_pkg::op_kind_e'(r.operation))
            lsi_tb_pkg::OPK_CLEAR:
                table_reset();
            lsi_tb_pkg::OPK_BYTE, lsi_tb_pkg::OPK_EOT:
            begin
                if (text_done)
                    o.status = lsi_pkg::ST_DONE;
                else if (r.operation == lsi_pkg::OP_BYTE)
                begin
                    if (cr_pending)
                    begin
                        cr_pending = 1'b0;
                        if (ch == lsi_pkg::CH_LF)
                        begin
                            close_open_line(scan_pos + 24'd1, o.lines_added, o.status);
                            ch = 8'd0;
                        end
                        else
                            close_open_line(scan_pos, o.lines_added, o.status);
                    end
                    if (ch == lsi_pkg::CH_LF)
                        close_open_line(scan_pos + 24'd1, o.lines_added, o.status);
                    else if (ch == lsi_pkg::CH_CR)
                        cr_pending = 1'b1;
                    scan_pos = scan_pos + 24'd1;
                end
                else
                begin
                    o.status = lsi_pkg::ST_DONE;
                    if (cr_pending)
                    begin
                        cr_pending = 1'b0;
                        close_open_line(scan_pos, o.lines_added, o.status);
                    end
                    close_open_line(scan_pos, o.lines_added, o.status);
                    text_done = 1'b1;
                end
            end
            lsi_tb_pkg::OPK_FIND, lsi_tb_pkg::OPK_EDIT:
            begin
                if (line_cnt == 0)
                    o.status = lsi_pkg::ST_RANGE;
                else
                begin
                    hit = 0;
                    for (int unsigned i = 0; i < line_cnt; i++)
                        if (line_start[i] <= r.byte_position)
                            hit = i;
                    o.found_line   = hit[11:0];
                    o.start_offset = line_start[hit];
                    o.length_bytes = line_len[hit];
                    if (r.operation == lsi_pkg::OP_EDIT)
                    begin
                        net = longint'(r.bytes_added) - longint'(r.bytes_removed);
                        nl  = longint'(line_len[hit]) + net;
                        if (nl < 0 || nl > longint'(POS_MAX))
                        begin
                            o.status = lsi_pkg::ST_BADEDIT;
                            edits_refused++;
                        end
                        else
                        begin
                            line_len[hit]  = nl[23:0];
                            o.length_bytes = nl[23:0];
                            for (int unsigned i = hit + 1; i < line_cnt; i++)
                                line_start[i] = line_start[i] + net[23:0];
                            edits_done++;
                        end
                    end
                end
            end
            lsi_tb_pkg::OPK_INFO:
            begin
                if (r.line_number < line_cnt)
                begin
                    o.start_offset = line_start[r.line_number];
                    o.length_bytes = line_len[r.line_number];
                end
                else
                    o.status = lsi_pkg::ST_RANGE;
            end
            default: ;
        endcase
        if (o.status == lsi_pkg::ST_FULL)
            full_hits++;
        o.total_lines = line_cnt[12:0];
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Sender: drive at the falling edge, bursts with random gaps.
    // ---------------------------------------------------------------
    int unsigned burst_left;

    task automatic send_request(input lsi_pkg::req_t r, input bit chk,
                                input lsi_pkg::rsp_t fx);
        int unsigned gap;
        if (burst_left == 0)
        begin
            // gap between bursts; sometimes none at all
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        // predict at the offer; accepted in order so the queue stays aligned
        expected_rsps.push_back(predict_line_rsp(r));
        fixed_flags.push_back(chk);
        fixed_rsps.push_back(fx);
        do
            @(posedge clk);
        while (!req_ch.ready);
        req_count++;
        burst_left--;
        @(negedge clk);
    endtask

    function automatic lsi_pkg::req_t make_req(input logic [2:0] op, input logic [7:0] b,
                                               input logic [23:0] pos, input logic [11:0] ln,
                                               input logic [23:0] ad, input logic [23:0] rm);
        lsi_pkg::req_t r;
        r.operation     = op;
        r.data_byte     = b;
        r.byte_position = pos;
        r.line_number   = ln;
        r.bytes_added   = ad;
        r.bytes_removed = rm;
        return r;
    endfunction

    function automatic lsi_pkg::rsp_t make_rsp(input logic [2:0] st, input logic [11:0] fl,
                                               input logic [23:0] so, input logic [23:0] lb,
                                               input logic [1:0] la, input logic [12:0] tl);
        lsi_pkg::rsp_t o;
        o.status       = st;
        o.found_line   = fl;
        o.start_offset = so;
        o.length_bytes = lb;
        o.lines_added  = la;
        o.total_lines  = tl;
        return o;
    endfunction

    // Random request with fully random payload bits; op chosen by caller.
    function automatic lsi_pkg::req_t rand_req(input logic [2:0] op);
        lsi_pkg::req_t r;
        r = make_req(op, 8'($urandom()), 24'($urandom()), 12'($urandom()),
                     24'($urandom()), 24'($urandom()));
        return r;
    endfunction

    function automatic logic [7:0] text_char();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 2)
            return lsi_pkg::CH_LF;
        if (k < 4)
            return lsi_pkg::CH_CR;
        return 8'($urandom());
    endfunction

    // Offset that hits near a stored line start, or anything at all.
    function automatic logic [23:0] probe_pos();
        int unsigned i;
        if (line_cnt == 0 || $urandom_range(0, 4) == 0)
            return 24'($urandom());
        i = $urandom_range(0, line_cnt - 1);
        return line_start[i] + 24'($signed($urandom_range(0, 4)) - 2);
    endfunction

    // Directed table: extremes, every operation and each special case.
    lsi_tb_pkg::stim_row_t dir_rows[$];

    task automatic add_row(input lsi_pkg::req_t r, input bit chk, input lsi_pkg::rsp_t fx);
        lsi_tb_pkg::stim_row_t s;
        s.req       = r;
        s.chk_fixed = chk;
        s.fixed     = fx;
        dir_rows.push_back(s);
    endtask

    task automatic build_directed();
        // empty table right after reset
        add_row(make_req(lsi_pkg::OP_FIND, '0, POS_MAX, '0, '0, '0), 1,
                make_rsp(lsi_pkg::ST_RANGE, '0, '0, '0, '0, '0));
        add_row(make_req(lsi_pkg::OP_EDIT, '0, '0, '0, POS_MAX, '0), 1,
                make_rsp(lsi_pkg::ST_RANGE, '0, '0, '0, '0, '0));
        add_row(make_req(lsi_pkg::OP_INFO, '0, '0, 12'hFFF, '0, '0), 1,
                make_rsp(lsi_pkg::ST_RANGE, '0, '0, '0, '0, '0));
        // empty text gives one empty line
        add_row(make_req(lsi_pkg::OP_EOT, '0, '0, '0, '0, '0), 1,
                make_rsp(lsi_pkg::ST_DONE, '0, '0, '0, 2'd1, 13'd1));
        // bytes after the end of text are ignored
        add_row(make_req(lsi_pkg::OP_BYTE, 8'hFF, '0, '0, '0, '0), 1,
                make_rsp(lsi_pkg::ST_DONE, '0, '0, '0, '0, 13'd1));
        add_row(make_req(lsi_pkg::OP_CLEAR, '0, '0, '0, '0, '0), 1,
                make_rsp(lsi_pkg::ST_OK, '0, '0, '0, '0, '0));
        // "a\r\nb\r\r\n" then CR right before end of text
        add_row(make_req(lsi_pkg::OP_BYTE, 8'h61, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_BYTE, lsi_pkg::CH_CR, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_BYTE, lsi_pkg::CH_LF, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_BYTE, 8'h62, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_BYTE, lsi_pkg::CH_CR, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_BYTE, lsi_pkg::CH_CR, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_BYTE, lsi_pkg::CH_LF, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_BYTE, lsi_pkg::CH_CR, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_EOT, '0, '0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_FIND, '0, 24'd0, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_FIND, '0, POS_MAX, '0, '0, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_INFO, '0, '0, 12'd2, '0, '0), 0, '0);
        // edit that would go negative is refused; maximal growth too large
        add_row(make_req(lsi_pkg::OP_EDIT, '0, 24'd1, '0, '0, POS_MAX), 0, '0);
        add_row(make_req(lsi_pkg::OP_EDIT, '0, 24'd0, '0, POS_MAX, '0), 0, '0);
        add_row(make_req(lsi_pkg::OP_EDIT, '0, 24'd3, '0, 24'd5, 24'd2), 0, '0);
        add_row(make_req(lsi_pkg::OP_INFO, '0, '0, 12'd3, '0, '0), 0, '0);
        // unused opcodes do nothing
        add_row(make_req(lsi_tb_pkg::OPK_SPARE6, 8'hFF, POS_MAX, 12'hFFF, POS_MAX, POS_MAX),
                0, '0);
        add_row(make_req(lsi_tb_pkg::OPK_SPARE7, '0, '0, '0, '0, '0), 0, '0);
    endtask

    // One text: clear, random bytes with line ends, then end of text in most runs.
    task automatic send_text(input int unsigned n_bytes);
        lsi_pkg::req_t r;
        send_request(rand_req(lsi_pkg::OP_CLEAR), 0, '0);
        repeat (n_bytes)
        begin
            r = rand_req(lsi_pkg::OP_BYTE);
            r.data_byte = text_char();
            send_request(r, 0, '0);
        end
        if ($urandom_range(0, 5) != 0)
            send_request(rand_req(lsi_pkg::OP_EOT), 0, '0);
    endtask

    task automatic send_queries(input int unsigned n);
        lsi_pkg::req_t r;
        int unsigned k;
        repeat (n)
        begin
            k = $urandom_range(0, 19);
            if (k < 7)
            begin
                r = rand_req(lsi_pkg::OP_FIND);
                r.byte_position = probe_pos();
            end
            else if (k < 12)
            begin
                r = rand_req(lsi_pkg::OP_INFO);
                if ($urandom_range(0, 3) != 0)
                    r.line_number = 12'($urandom_range(0, line_cnt + 1));
            end
            else if (k < 18)
            begin
                r = rand_req(lsi_pkg::OP_EDIT);
                r.byte_position = probe_pos();
                if ($urandom_range(0, 4) != 0)
                begin
                    // mostly small edits that keep lengths sane
                    r.bytes_added   = 24'($urandom_range(0, 8));
                    r.bytes_removed = 24'($urandom_range(0, 8));
                end
            end
            else if (k < 19)
                r = rand_req(($urandom_range(0, 1) == 0) ? lsi_pkg::OP_BYTE
                                                         : lsi_pkg::OP_EOT);
            else
                r = rand_req(($urandom_range(0, 1) == 0) ? lsi_tb_pkg::OPK_SPARE6
                                                         : lsi_tb_pkg::OPK_SPARE7);
            send_request(r, 0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall pattern plus one long hold-off on request.
    // ---------------------------------------------------------------
    int unsigned stall_mode;

    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_mode   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // long hold-off so the block backs up into its input
                rsp_ch.ready <= 1'b0;
                repeat (300)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Check each response against the oldest prediction at the rising edge.
    always @(posedge clk)
    begin
        lsi_pkg::rsp_t want;
        bit            chk;
        lsi_pkg::rsp_t fx;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_count++;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response %p", rsp_ch.payload);
            end
            else
            begin
                want = expected_rsps.pop_front();
                chk  = fixed_flags.pop_front();
                fx   = fixed_rsps.pop_front();
                if (chk && fx !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: table row answer %p vs predicted %p", fx, want);
                end
                if (rsp_ch.payload !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: response %0d exp %p got %p",
                                 rsp_count, want, rsp_ch.payload);
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int unsigned drain;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        mismatches = 0;
        rsp_count  = 0;
        req_count  = 0;
        idle_cycles = 0;
        edits_done = 0;
        edits_refused = 0;
        full_hits  = 0;
        burst_left = 0;
        hold_off_req = 1'b0;
        held_off   = 1'b0;
        table_reset();
        build_directed();

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].chk_fixed, dir_rows[i].fixed);

        // random part: short texts followed by queries and edits
        while (req_count < N_RANDOM)
        begin
            if (req_count > 600 && !held_off)
            begin
                held_off     = 1'b1;
                hold_off_req = 1'b1;
            end
            send_text($urandom_range(0, 3) == 0 ? $urandom_range(0, 3)
                                                : $urandom_range(4, 40));
            send_queries($urandom_range(4, 20));
        end

        req_ch.valid <= 1'b0;
        drain = 0;
        while (expected_rsps.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20)
            @(posedge clk);

        $display("Ran %0d requests, %0d responses over texts, queries and edits",
                 req_count, rsp_count);
        $display("%0d edits applied, %0d refused, %0d full drops",
                 edits_done, edits_refused, full_hits);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== line_start_index_top.f =====
rtl/core/lsi_pkg.sv
rtl/core/lsi_req_if.sv
rtl/core/lsi_ram.sv
rtl/core/line_start_index_top.sv
rtl/core/lsi_checker.sv
test/line_start_index_tb_if.sv
test/line_start_index_top_tb.sv
